>>> hw/rtl/fadd_pkg.sv
// ----------------------------------------------------------------------------
// fadd_pkg
// Shared types and constants of the float add / convert pipeline.
// ----------------------------------------------------------------------------
package fadd_pkg;

	// request codes
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_FLOOR = 2'd1;
	localparam logic [1:0] REQ_CONV  = 2'd2;

	// 2^23 as a float word, the implicit second operand of floor and convert
	localparam logic [31:0] TWO_POW_23_WORD = 32'h4B00_0000;
	// exponent given to an integer operand
	localparam logic [7:0]  CONV_EXP        = 8'd150;
	// largest alignment shift
	localparam logic [4:0]  SHIFT_CAP       = 5'd31;
	// shift that moves the rounding bit into the hidden-bit place
	localparam logic [4:0]  ZERO_NORM_SHIFT = 5'd24;

	// input beat
	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} req_t;

	// unpacked operands after stage one
	typedef struct packed {
		logic               flr;
		logic               conv;
		logic               xn;
		logic               yn;
		logic [31:0]        x;
		logic [31:0]        y;
		logic               xs;
		logic               ys;
		logic signed [25:0] x0;
		logic signed [25:0] y0;
		logic               shift_x;
		logic [4:0]         sh;
		logic [7:0]         e0;
	} unp_t;

	// aligned sum after stage two
	typedef struct packed {
		logic        flr;
		logic        conv;
		logic        xn;
		logic        yn;
		logic [31:0] x;
		logic [31:0] y;
		logic [26:0] sum;
		logic [26:0] mag;
		logic [7:0]  e0;
	} sum_t;

endpackage

>>> hw/rtl/fadd_if.sv
// ----------------------------------------------------------------------------
// fadd_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface fadd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source (output valid, output req_type, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input req_type, input operand_a, input operand_b,
		output ready);
endinterface

interface fadd_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_word;

	modport source (output valid, output result_word, input ready);
	modport sink (input valid, input result_word, output ready);
endinterface

>>> hw/rtl/fadd_unpack.sv
// ----------------------------------------------------------------------------
// fadd_unpack
// Stage one: operand unpacking, signed mantissas and exponent compare.
// ----------------------------------------------------------------------------
module fadd_unpack (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  fadd_pkg::req_t in_data,
	output logic          valid_s1,
	output fadd_pkg::unp_t data_s1
);
	import fadd_pkg::*;

	logic        conv, flr;
	logic [31:0] y;
	logic [24:0] xm, ym;
	logic [7:0]  xe, ye;
	logic [8:0]  diff;
	unp_t        nxt;

	always_comb begin
		conv = (in_data.req_type == REQ_CONV);
		flr  = (in_data.req_type == REQ_FLOOR);
		y    = (conv || flr) ? TWO_POW_23_WORD : in_data.operand_b;

		// first operand: float or signed 24-bit integer
		xm = {1'b1, in_data.operand_a[22:0], 1'b0};
		if (conv) begin
			xe     = CONV_EXP;
			nxt.x0 = {in_data.operand_a[23], in_data.operand_a[23:0], 1'b0};
		end else begin
			xe     = in_data.operand_a[30:23];
			nxt.x0 = in_data.operand_a[31] ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
		end

		// second operand, hidden bit except for floor and convert
		ye     = y[30:23];
		ym     = {~(conv || flr), y[22:0], 1'b0};
		nxt.y0 = y[31] ? -$signed({1'b0, ym}) : $signed({1'b0, ym});

		// exponent compare and capped shift
		nxt.shift_x = (ye > xe);
		diff        = nxt.shift_x ? ({1'b0, ye} - {1'b0, xe}) : ({1'b0, xe} - {1'b0, ye});
		nxt.sh      = (diff > {4'd0, SHIFT_CAP}) ? SHIFT_CAP : diff[4:0];
		nxt.e0      = nxt.shift_x ? ye : xe;

		nxt.flr  = flr;
		nxt.conv = conv;
		nxt.xn   = (in_data.operand_a[30:0] == 31'd0);
		nxt.yn   = (y[30:0] == 31'd0);
		nxt.x    = in_data.operand_a;
		nxt.y    = y;
		nxt.xs   = in_data.operand_a[31];
		nxt.ys   = y[31];
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end
endmodule

>>> hw/rtl/fadd_align.sv
// ----------------------------------------------------------------------------
// fadd_align
// Stage two: alignment shift, 27-bit sum and rounded magnitude.
// ----------------------------------------------------------------------------
module fadd_align (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  fadd_pkg::unp_t in_data,
	output logic           valid_s2,
	output fadd_pkg::sum_t data_s2
);
	import fadd_pkg::*;

	logic signed [25:0] a3, b3;
	logic [26:0]        sum, mag;
	sum_t               nxt;

	always_comb begin
		// shift the operand with the smaller exponent
		a3 = in_data.shift_x ? (in_data.x0 >>> in_data.sh) : in_data.x0;
		b3 = in_data.shift_x ? in_data.y0 : (in_data.y0 >>> in_data.sh);

		sum = {in_data.xs, in_data.xs, a3[24:0]} + {in_data.ys, in_data.ys, b3[24:0]};
		mag = (sum[26] ? -sum : sum) + 27'd1;

		nxt.flr  = in_data.flr;
		nxt.conv = in_data.conv;
		nxt.xn   = in_data.xn;
		nxt.yn   = in_data.yn;
		nxt.x    = in_data.x;
		nxt.y    = in_data.y;
		nxt.sum  = sum;
		nxt.mag  = mag;
		nxt.e0   = in_data.e0;
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end
endmodule

>>> hw/rtl/fadd_norm.sv
// ----------------------------------------------------------------------------
// fadd_norm
// Stage three: leading-one search, normalize, pack and result select.
// ----------------------------------------------------------------------------
module fadd_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  fadd_pkg::sum_t in_data,
	output logic           valid_s3,
	output logic [31:0]    result_s3
);
	import fadd_pkg::*;

	logic [25:0] t3;
	logic [4:0]  lead;
	logic [4:0]  sh;
	logic [24:0] norm;
	logic [9:0]  e1;
	logic [31:0] res;

	always_comb begin
		t3 = in_data.mag[26:1];

		// highest set bit below the hidden-bit place
		lead = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (t3[i]) begin
				lead = 5'(i);
			end
		end
		sh   = t3[24] ? 5'd0 : (ZERO_NORM_SHIFT - lead);
		norm = t3[24:0] << sh;
		e1   = {2'd0, in_data.e0} + 10'd1 - {5'd0, sh};

		// result select, floor first
		priority if (in_data.flr) begin
			res = {{6{in_data.sum[26]}}, in_data.sum[26:1]};
		end else if (in_data.xn) begin
			res = (in_data.conv || in_data.yn) ? 32'd0 : in_data.y;
		end else if (in_data.yn) begin
			res = in_data.x;
		end else if (norm == 25'd0 || e1[8]) begin
			res = 32'd0;
		end else begin
			res = {in_data.sum[26], e1[7:0], norm[23:1]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s3 <= res;
		end
	end
endmodule

>>> hw/rtl/float_add_convert_unit.sv
// ----------------------------------------------------------------------------
// float_add_convert_unit
// Single-precision float add, float floor and integer-to-float convert.
// ----------------------------------------------------------------------------
// Three register stages (unpack, align and sum, normalize and pack) carry each
// request beat to a result beat, one beat per cycle while rsp.ready is high.
// Each stage holds its beat while the one after it is full and cannot drain,
// so a stalled result side fills the pipeline and drops req.ready only when
// all three stages hold a beat.
module float_add_convert_unit (
	input  logic       clk,
	input  logic       arst_n,
	fadd_req_if.sink   req,
	fadd_rsp_if.source rsp
);
	import fadd_pkg::*;

	req_t        req_data;
	unp_t        data_s1;
	sum_t        data_s2;
	logic        valid_s1, valid_s2, valid_s3;
	logic        en1, en2, en3;
	logic [31:0] result_s3;

	// stage enables, a stage loads when empty or when it drains
	assign en3 = !valid_s3 || rsp.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign req.ready = en1;
	assign req_data  = '{req_type: req.req_type, operand_a: req.operand_a,
		operand_b: req.operand_b};

	fadd_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.in_valid (req.valid),
		.in_data  (req_data),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	fadd_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.in_valid (valid_s1),
		.in_data  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	fadd_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en3),
		.in_valid  (valid_s2),
		.in_data   (data_s2),
		.valid_s3  (valid_s3),
		.result_s3 (result_s3)
	);

	assign rsp.valid       = valid_s3;
	assign rsp.result_word = result_s3;
endmodule

>>> hw/rtl/fadd_checker.sv
// ----------------------------------------------------------------------------
// fadd_checker
// Port-level checks of the float add / convert pipeline.
// ----------------------------------------------------------------------------
module fadd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// backpressure only when a result is waiting and stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request side blocked without a stalled result");

	// with the result side ready, an accepted request beat shows up as a result beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result beat missing after unstalled latency");
endmodule

bind float_add_convert_unit fadd_checker u_fadd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.result_word)
);

>>> dv/float_add_convert_unit_tb.sv
// ----------------------------------------------------------------------------
// float_add_convert_unit testbench
// Drives add, floor and convert requests through the valid/ready channels
// with random idling and backpressure, predicts each result word and checks
// results in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fadd_pkg::*;

	logic clk;
	logic arst_n;

	fadd_req_if req_ch ();
	fadd_rsp_if rsp_ch ();

	float_add_convert_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	logic [31:0] expected_words[$];
	int          error_count;
	bit          src_no_idle;
	bit          snk_no_idle;
	bit          snk_hold;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// arithmetic shift right of a 32-bit pattern
	function automatic logic [31:0] sra32(logic [31:0] v, int unsigned sh);
		return $unsigned($signed(v) >>> sh);
	endfunction

	// expected result word of one request
	function automatic logic [31:0] predict_word(logic [1:0] op, logic [31:0] x,
			logic [31:0] y);
		logic        conv;
		logic        flr;
		logic        xs;
		logic        ys;
		logic        xn;
		logic        yn;
		logic [31:0] xe;
		logic [31:0] ye;
		logic [31:0] x0;
		logic [31:0] y0;
		logic [31:0] ym;
		logic [31:0] e0;
		logic [31:0] x3;
		logic [31:0] y3;
		logic [31:0] sum;
		logic [31:0] s;
		logic [31:0] e1;
		logic [31:0] t3;
		logic [31:0] sh;
		logic [31:0] t;
		conv = (op == REQ_CONV);
		flr = (op == REQ_FLOOR);
		if (conv || flr) y = TWO_POW_23_WORD;
		xs = x[31];
		if (!conv) begin
			xe = {24'd0, x[30:23]};
			x0 = {7'd0, 1'b1, x[22:0], 1'b0};
			if (xs) x0 = 32'd0 - x0;
		end else begin
			t = {{8{x[23]}}, x[23:0]};
			xe = 32'd150;
			x0 = t << 1;
		end
		ys = y[31];
		ye = {24'd0, y[30:23]};
		ym = {8'd0, y[22:0], 1'b0};
		if (!conv && !flr) ym[24] = 1'b1;
		y0 = ys ? 32'd0 - ym : ym;
		if (ye > xe) begin
			sh = ye - xe;
			e0 = ye;
			x3 = sra32(x0, sh > 31 ? 31 : sh);
			y3 = y0;
		end else begin
			sh = xe - ye;
			e0 = xe;
			x3 = x0;
			y3 = sra32(y0, sh > 31 ? 31 : sh);
		end
		sum = {5'd0, xs, xs, x3[24:0]} + {5'd0, ys, ys, y3[24:0]};
		s = ((sum[26] ? 32'd0 - sum : sum) + 32'd1) & 32'h07FF_FFFF;
		e1 = e0 + 1;
		t3 = s >> 1;
		if ((s & 32'h03FF_FFFC) != 0) begin
			while (t3[24] == 1'b0) begin
				t3 = t3 << 1;
				e1 = e1 - 1;
			end
		end else begin
			t3 = t3 << 24;
			e1 = e1 - 24;
		end
		xn = (x[30:0] == 31'd0);
		yn = (y[30:0] == 31'd0);
		if (flr) return sra32(sum << 5, 6);
		if (xn) return (conv || yn) ? 32'd0 : y;
		if (yn) return x;
		if (t3[24:0] == 25'd0 || e1[8]) return 32'd0;
		return {sum[26], e1[7:0], t3[23:1]};
	endfunction

	// send one request beat and record its expected result
	// valid stays high after the beat so the next one can follow directly
	task automatic send_request(logic [1:0] op, logic [31:0] a, logic [31:0] b);
		while (!src_no_idle && $urandom_range(99) < 32) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= op;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_words.push_back(predict_word(op, a, b));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// random float word, biased toward nearby exponents and zeros
	function automatic logic [31:0] rand_float(logic [7:0] near_exp);
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(9))
			0: w[30:0] = 31'd0;
			1, 2: w[30:23] = near_exp;
			3, 4, 5: w[30:23] = near_exp + 8'($urandom_range(60)) - 8'd30;
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] rand_int24();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(5))
			0: w[23:0] = 24'($urandom_range(255));
			1: w[23:0] = 24'd0 - 24'($urandom_range(255));
			default: ;
		endcase
		return w;
	endfunction

	// extremes and special cases of each operation
	task automatic test_directed();
		send_request(REQ_ADD, 32'h3F80_0000, 32'h3F80_0000);
		send_request(REQ_ADD, 32'h3F80_0000, 32'hBF80_0000);
		send_request(REQ_ADD, 32'h0000_0000, 32'h4040_0000);
		send_request(REQ_ADD, 32'h8000_0000, 32'hC040_0000);
		send_request(REQ_ADD, 32'h4120_0000, 32'h8000_0000);
		send_request(REQ_ADD, 32'h8000_0000, 32'h0000_0000);
		send_request(REQ_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_request(REQ_ADD, 32'h0000_0001, 32'h8000_0002);
		send_request(REQ_ADD, 32'h7F80_0000, 32'h0080_0000);
		send_request(REQ_ADD, 32'h0080_0000, 32'h8080_0001);
		send_request(REQ_ADD, 32'h3F80_0001, 32'h3300_0000);
		send_request(REQ_FLOOR, 32'h4049_0FDB, 32'h0);
		send_request(REQ_FLOOR, 32'hC049_0FDB, 32'hFFFF_FFFF);
		send_request(REQ_FLOOR, 32'h0000_0000, 32'h0);
		send_request(REQ_FLOOR, 32'h7FFF_FFFF, 32'h0);
		send_request(REQ_FLOOR, 32'hFFFF_FFFF, 32'h0);
		send_request(REQ_CONV, 32'h0000_0000, 32'h1234_5678);
		send_request(REQ_CONV, 32'hFF00_0000, 32'h0);
		send_request(REQ_CONV, 32'h0000_0001, 32'h0);
		send_request(REQ_CONV, 32'h00FF_FFFF, 32'h0);
		send_request(REQ_CONV, 32'h007F_FFFF, 32'h0);
		send_request(REQ_CONV, 32'hFF80_0000, 32'h0);
		send_request(2'd3, 32'h4000_0000, 32'h4000_0000);
		send_request(2'd3, 32'h0000_0000, 32'h0);
		wait_drained();
	endtask

	task automatic test_random(int count);
		logic [1:0]  op;
		logic [31:0] a;
		for (int i = 0; i < count; i++) begin
			src_no_idle = (i >= count / 2 && i < count / 2 + 150);
			snk_no_idle = src_no_idle;
			op = 2'($urandom_range(3));
			if ($urandom_range(9) < 5) op = REQ_ADD;
			a = (op == REQ_CONV) ? rand_int24() : rand_float(8'($urandom_range(255)));
			send_request(op, a, rand_float(a[30:23]));
		end
		src_no_idle = 1'b0;
		snk_no_idle = 1'b0;
	endtask

	// result side holds off while add requests keep coming, then drain fully and send convert requests
	task automatic test_backpressure();
		snk_hold = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				snk_hold = 1'b0;
			end
			for (int i = 0; i < 20; i++)
				send_request(REQ_ADD, rand_float(8'd127), rand_float(8'd127));
		join
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_request(REQ_CONV, rand_int24(), 32'h0);
		wait_drained();
	endtask

	// result ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !snk_hold && (snk_no_idle || $urandom_range(99) >= 32);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		logic [31:0] exp_word;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%t: unexpected result beat, actual %h", $realtime,
					rsp_ch.result_word);
				error_count++;
			end else begin
				exp_word = expected_words.pop_front();
				if (rsp_ch.result_word !== exp_word) begin
					$display("%t: result_word mismatch, expected %h actual %h",
						$realtime, exp_word, rsp_ch.result_word);
					error_count++;
				end
			end
		end
	end

	initial begin
		error_count = 0;
		src_no_idle = 1'b0;
		snk_no_idle = 1'b0;
		snk_hold = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_ADD;
		req_ch.operand_a = 32'd0;
		req_ch.operand_b = 32'd0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1400);
		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
